### rtl/core/cnc_command_frame_parser_assert.svh
// assertion macros for the command frame parser
// included by cnc_command_frame_parser.sv; empty bodies when SYNTHESIS is defined
`ifndef CNC_COMMAND_FRAME_PARSER_ASSERT_SVH
`define CNC_COMMAND_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CNCFP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define CNCFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define CNCFP_ASSERT_SAME(label, clk, rst, ante, cons)
`define CNCFP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/cncfp_pkg.sv
// types and constants for the command frame parser
// no dependencies
`default_nettype none

package cncfp_pkg;

  localparam int NUM_KEYS = 4;
  localparam int MAG_W    = 10;
  localparam int VAL_W    = 11;
  localparam int ACC_W    = 14;

  localparam logic [MAG_W-1:0] MAG_MAX = 10'd1023;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_EQUALS = 8'h3D;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_M      = 8'h4D;
  localparam logic [7:0] CHAR_THREE  = 8'h33;
  localparam logic [7:0] CHAR_FOUR   = 8'h34;

  // key letters, index 0 S, 1 X, 2 Y, 3 Z
  localparam logic [7:0] KEY_LETTER [NUM_KEYS] = '{8'h53, 8'h58, 8'h59, 8'h5A};

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

endpackage

`default_nettype wire

### rtl/core/cnc_command_frame_parser.sv
// command frame parser: '$' ... '#' frames, S= X= Y= Z= values, M3/M4 flags
// depends on cncfp_pkg and cnc_command_frame_parser_assert.svh
//
//  channel   signals                          direction  notes
//  rx        rx_valid rx_ready rx_byte        in         one ascii byte per transaction
//  res       res_valid res_ready *_value ...  out        one transaction per closing '#'
//
// each byte is handled in the cycle it is accepted; one per cycle while rx_ready is high
// a result sits in the output register; rx stays ready while it is taken
// rx_ready drops only while a result waits and res_ready is low
// synchronous reset clears the frame state and the held values to zero
`default_nettype none

module cnc_command_frame_parser #(
  parameter int VALUE_CHARS = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rx_valid,
  output logic             rx_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic signed [cncfp_pkg::VAL_W-1:0] spindle_value,
  output logic signed [cncfp_pkg::VAL_W-1:0] x_value,
  output logic signed [cncfp_pkg::VAL_W-1:0] y_value,
  output logic signed [cncfp_pkg::VAL_W-1:0] z_value,
  output logic             cw_seen,
  output logic             ccw_seen,
  output logic [cncfp_pkg::NUM_KEYS-1:0] keys_found
);

  import cncfp_pkg::*;

  localparam int CNT_W = $clog2(VALUE_CHARS + 1);

  logic                    in_frame, in_frame_next;
  logic [7:0]              previous_char, previous_char_next;
  logic [NUM_KEYS-1:0]     key_seen, key_seen_next;
  logic [1:0]              motion_flags, motion_flags_next;
  phase_t                  capture_phase [NUM_KEYS];
  phase_t                  capture_phase_next [NUM_KEYS];
  logic [CNT_W-1:0]        capture_chars [NUM_KEYS];
  logic [CNT_W-1:0]        capture_chars_next [NUM_KEYS];
  logic                    capture_negative [NUM_KEYS];
  logic                    capture_negative_next [NUM_KEYS];
  logic [MAG_W-1:0]        capture_magnitude [NUM_KEYS];
  logic [MAG_W-1:0]        capture_magnitude_next [NUM_KEYS];
  logic signed [VAL_W-1:0] held_value [NUM_KEYS];
  logic signed [VAL_W-1:0] held_value_next [NUM_KEYS];
  logic                    res_valid_next;
  logic                    cw_seen_next, ccw_seen_next;
  logic [NUM_KEYS-1:0]     keys_found_next;

  logic                    rx_accept;
  logic                    is_blank, is_digit, is_sign;
  logic [3:0]              digit_val;
  logic [ACC_W-1:0]        acc [NUM_KEYS];
  logic [MAG_W-1:0]        mag_added [NUM_KEYS];
  logic [NUM_KEYS-1:0]     not_idle;

  assign rx_ready  = !res_valid || res_ready;
  assign rx_accept = rx_valid && rx_ready;

  assign is_blank  = (rx_byte == CHAR_SPACE) || (rx_byte >= CHAR_TAB && rx_byte <= CHAR_CR);
  assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
  assign is_sign   = (rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS);
  assign digit_val = 4'(rx_byte - CHAR_ZERO);

  // saturating magnitude * 10 + digit, per key
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      acc[k] = ({{(ACC_W-MAG_W){1'b0}}, capture_magnitude[k]} << 3)
             + ({{(ACC_W-MAG_W){1'b0}}, capture_magnitude[k]} << 1)
             + {{(ACC_W-4){1'b0}}, digit_val};
      mag_added[k] = (acc[k] > {{(ACC_W-MAG_W){1'b0}}, MAG_MAX}) ? MAG_MAX
                                                                 : acc[k][MAG_W-1:0];
      not_idle[k]  = (capture_phase[k] != PH_IDLE);
    end
  end

  always_comb begin
    logic [MAG_W:0] ext;
    ext                = '0;
    in_frame_next      = in_frame;
    previous_char_next = previous_char;
    key_seen_next      = key_seen;
    motion_flags_next  = motion_flags;
    res_valid_next     = res_valid && !res_ready;
    cw_seen_next       = cw_seen;
    ccw_seen_next      = ccw_seen;
    keys_found_next    = keys_found;
    for (int k = 0; k < NUM_KEYS; k++) begin
      capture_phase_next[k]     = capture_phase[k];
      capture_chars_next[k]     = capture_chars[k];
      capture_negative_next[k]  = capture_negative[k];
      capture_magnitude_next[k] = capture_magnitude[k];
      held_value_next[k]        = held_value[k];
    end

    if (rx_accept) begin
      if (!in_frame) begin
        if (rx_byte == CHAR_DOLLAR) begin
          in_frame_next      = 1'b1;
          previous_char_next = rx_byte;
          key_seen_next      = '0;
          motion_flags_next  = '0;
          for (int k = 0; k < NUM_KEYS; k++) begin
            capture_phase_next[k]     = PH_IDLE;
            capture_chars_next[k]     = '0;
            capture_negative_next[k]  = 1'b0;
            capture_magnitude_next[k] = '0;
          end
        end
      end else if (rx_byte == CHAR_HASH) begin
        // frame close: store found values and present the result
        for (int k = 0; k < NUM_KEYS; k++) begin
          ext = {1'b0, capture_magnitude[k]};
          if (key_seen[k]) begin
            held_value_next[k] = capture_negative[k] ? -$signed(ext) : $signed(ext);
          end
          capture_phase_next[k]     = PH_IDLE;
          capture_chars_next[k]     = '0;
          capture_negative_next[k]  = 1'b0;
          capture_magnitude_next[k] = '0;
        end
        res_valid_next     = 1'b1;
        cw_seen_next       = motion_flags[0];
        ccw_seen_next      = motion_flags[1];
        keys_found_next    = key_seen;
        in_frame_next      = 1'b0;
        previous_char_next = rx_byte;
        key_seen_next      = '0;
        motion_flags_next  = '0;
      end else begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (capture_phase[k] == PH_SIGN || capture_phase[k] == PH_DIGITS) begin
            if (capture_phase[k] == PH_SIGN && is_blank) begin
              capture_phase_next[k] = PH_SIGN;
            end else if (capture_phase[k] == PH_SIGN && is_sign) begin
              capture_negative_next[k] = (rx_byte == CHAR_MINUS);
              capture_phase_next[k]    = PH_DIGITS;
            end else if (is_digit) begin
              capture_magnitude_next[k] = mag_added[k];
              capture_phase_next[k]     = PH_DIGITS;
            end else begin
              capture_phase_next[k] = PH_DONE;
            end
            if (capture_phase_next[k] != PH_DONE) begin
              capture_chars_next[k] = capture_chars[k] + CNT_W'(1);
              if (capture_chars_next[k] >= CNT_W'(VALUE_CHARS)) begin
                capture_phase_next[k] = PH_DONE;
              end
            end
          end
          // first occurrence of a key starts its capture
          if (rx_byte == CHAR_EQUALS && previous_char == KEY_LETTER[k] && !key_seen[k]) begin
            key_seen_next[k]          = 1'b1;
            capture_phase_next[k]     = PH_SIGN;
            capture_chars_next[k]     = '0;
            capture_negative_next[k]  = 1'b0;
            capture_magnitude_next[k] = '0;
          end
        end
        if (previous_char == CHAR_M && rx_byte == CHAR_THREE) begin
          motion_flags_next[0] = 1'b1;
        end
        if (previous_char == CHAR_M && rx_byte == CHAR_FOUR) begin
          motion_flags_next[1] = 1'b1;
        end
        previous_char_next = rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      previous_char <= '0;
      key_seen      <= '0;
      motion_flags  <= '0;
      res_valid     <= 1'b0;
      cw_seen       <= 1'b0;
      ccw_seen      <= 1'b0;
      keys_found    <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        capture_phase[k]     <= PH_IDLE;
        capture_chars[k]     <= '0;
        capture_negative[k]  <= 1'b0;
        capture_magnitude[k] <= '0;
        held_value[k]        <= '0;
      end
    end else begin
      in_frame      <= in_frame_next;
      previous_char <= previous_char_next;
      key_seen      <= key_seen_next;
      motion_flags  <= motion_flags_next;
      res_valid     <= res_valid_next;
      cw_seen       <= cw_seen_next;
      ccw_seen      <= ccw_seen_next;
      keys_found    <= keys_found_next;
      for (int k = 0; k < NUM_KEYS; k++) begin
        capture_phase[k]     <= capture_phase_next[k];
        capture_chars[k]     <= capture_chars_next[k];
        capture_negative[k]  <= capture_negative_next[k];
        capture_magnitude[k] <= capture_magnitude_next[k];
        held_value[k]        <= held_value_next[k];
      end
    end
  end

  assign spindle_value = held_value[0];
  assign x_value       = held_value[1];
  assign y_value       = held_value[2];
  assign z_value       = held_value[3];

  `include "cnc_command_frame_parser_assert.svh"

  `CNCFP_ASSERT_SAME(a_stall_only_on_result, clk, rst, !rx_ready, res_valid)
  `CNCFP_ASSERT_SAME(a_unseen_key_idle, clk, rst, 1'b1, (not_idle & ~key_seen) == '0)
  `CNCFP_ASSERT_SAME(a_outside_frame_clear, clk, rst, !in_frame, key_seen == '0 && motion_flags == '0)
  `CNCFP_ASSERT_NEXT(a_close_gives_result, clk, rst, rx_accept && in_frame && rx_byte == CHAR_HASH, res_valid && !in_frame)
  `CNCFP_ASSERT_NEXT(a_dropped_byte_no_effect, clk, rst, rx_accept && !in_frame && rx_byte != CHAR_DOLLAR, !in_frame && $stable(previous_char))

endmodule

`default_nettype wire
